// File: src/lslf_pkg.sv
// Package for the least-squares line fit unit: widths, types and constants.
// No dependencies.
`default_nettype none
package lslf_pkg;
  localparam int MaxPointsDefault = 16;
  localparam int XW   = 17;
  localparam int SW   = 24;
  localparam int PW   = 40;
  localparam int NW   = 5;
  localparam int OW   = 32;
  // Numerator and denominator width for the divider.
  localparam int DW   = 88;
  localparam int MW   = 24;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic mul_start;
    logic [3:0] mul_sel;
    logic mul_acc;
    logic div_start;
    logic div_sel;
    logic out_load;
    logic fit_end;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic target_hit;
    logic den_pos;
  } stat_t;
endpackage
`default_nettype wire

// File: src/lslf_mul.sv
// Sequential signed multiplier that works through b in 4-bit digits.
// Depends on lslf_pkg.
`default_nettype none
module lslf_mul (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [lslf_pkg::DW-1:0] a,
  input  wire logic signed [lslf_pkg::PW-1:0] b,
  output logic busy,
  output logic signed [lslf_pkg::DW-1:0] prod
);
  // Shift-and-add, 4 bits of b per cycle, magnitude form.
  logic [lslf_pkg::DW-1:0] ma;
  logic [lslf_pkg::PW-1:0] mb;
  logic [lslf_pkg::DW-1:0] acc;
  logic neg;
  logic [3:0] cnt;
  logic [lslf_pkg::DW-1:0] part;
  logic [lslf_pkg::DW-1:0] acc_next;
  always_comb begin
    part = (mb[0] ? ma : '0) + (mb[1] ? (ma << 1) : '0)
         + (mb[2] ? (ma << 2) : '0) + (mb[3] ? (ma << 3) : '0);
    acc_next = acc + part;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 4'd10;
      neg <= a[lslf_pkg::DW-1] ^ b[lslf_pkg::PW-1];
      ma <= a[lslf_pkg::DW-1] ? -a : a;
      mb <= b[lslf_pkg::PW-1] ? -b : b;
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
      ma <= ma << 4;
      mb <= mb >> 4;
      cnt <= cnt - 4'd1;
      if (cnt == 4'd1) begin
        busy <= 1'b0;
        prod <= neg ? -acc_next : acc_next;
      end
    end
  end
endmodule
`default_nettype wire

// File: src/lslf_div.sv
// Restoring divider, round half away from zero, saturate to 32 bits.
// Depends on lslf_pkg.
`default_nettype none
module lslf_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [lslf_pkg::DW-1:0] num,
  input  wire logic [lslf_pkg::DW-1:0] den,
  output logic busy,
  output logic signed [lslf_pkg::OW-1:0] q
);
  localparam int QB = 34;
  logic [lslf_pkg::DW-1:0] mag;
  logic [lslf_pkg::DW-1:0] d;
  logic [lslf_pkg::DW:0] rem;
  logic [QB-1:0] quo;
  logic ovf;
  logic neg;
  logic [6:0] cnt;
  logic [1:0] ph;
  logic [lslf_pkg::DW:0] trial;
  always_comb begin
    trial = {rem[lslf_pkg::DW-1:0], mag[lslf_pkg::DW-1]} - {1'b0, d};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ph <= '0;
    end else if (start) begin
      busy <= 1'b1;
      ph <= 2'd1;
      neg <= num[lslf_pkg::DW-1];
      mag <= num[lslf_pkg::DW-1] ? -num : num;
      d <= den;
    end else if (busy) begin
      unique case (ph)
        2'd1: begin
          // add half the divisor
          mag <= mag + (d >> 1);
          rem <= '0;
          quo <= '0;
          ovf <= 1'b0;
          cnt <= 7'(lslf_pkg::DW);
          ph <= 2'd2;
        end
        2'd2: begin
          mag <= mag << 1;
          if (!trial[lslf_pkg::DW]) begin
            rem <= trial;
            quo <= {quo[QB-2:0], 1'b1};
          end else begin
            rem <= {rem[lslf_pkg::DW-1:0], mag[lslf_pkg::DW-1]};
            quo <= {quo[QB-2:0], 1'b0};
          end
          if (quo[QB-1]) ovf <= 1'b1;
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) ph <= 2'd3;
        end
        2'd3: begin
          busy <= 1'b0;
          ph <= 2'd0;
          if (neg) begin
            if (ovf || quo > 34'h80000000) q <= 32'sh80000000;
            else q <= -quo[31:0];
          end else begin
            if (ovf || quo > 34'h7FFFFFFF) q <= 32'sh7FFFFFFF;
            else q <= quo[31:0];
          end
        end
        default: ph <= 2'd0;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/lslf_datapath.sv
// Datapath: running sums, product terms, shared multiplier and divider.
// Depends on lslf_pkg, lslf_mul, lslf_div.
`default_nettype none
module lslf_datapath #(
  parameter int MAX_POINTS = lslf_pkg::MaxPointsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [lslf_pkg::NW-1:0] cfg_data,
  input  wire logic signed [lslf_pkg::XW-1:0] x_in,
  input  wire logic signed [lslf_pkg::XW-1:0] y_in,
  input  wire logic restart,
  input  wire lslf_pkg::cmd_t cmd,
  output lslf_pkg::stat_t stat,
  output logic [lslf_pkg::NW-1:0] taken,
  output logic done,
  output logic degen,
  output logic signed [lslf_pkg::OW-1:0] slope,
  output logic signed [lslf_pkg::OW-1:0] intercept
);
  localparam int DW = lslf_pkg::DW;
  logic [lslf_pkg::NW-1:0] pc;
  logic [5:0] tgt;
  logic signed [lslf_pkg::SW-1:0] sx, sy;
  logic signed [lslf_pkg::PW-1:0] sxy, sxx;
  logic [5:0] n;
  logic signed [lslf_pkg::XW-1:0] xr, yr;
  logic signed [DW-1:0] den, snum, inum, t;
  logic signed [DW-1:0] ma;
  logic signed [lslf_pkg::PW-1:0] mb;
  logic signed [DW-1:0] prod;
  logic signed [DW-1:0] dnum;
  logic signed [lslf_pkg::OW-1:0] q;
  logic mbusy, dbusy;

  always_ff @(posedge clk) begin
    if (rst) pc <= lslf_pkg::NW'(1);
    else if (cfg_we) pc <= cfg_data;
  end
  always_comb begin
    if (pc == '0) tgt = 6'd1;
    else if (32'(pc) > MAX_POINTS) tgt = 6'(MAX_POINTS);
    else tgt = {1'b0, pc};
  end

  // Operand select for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_sel)
      4'd0: begin ma = DW'(xr); mb = lslf_pkg::PW'(yr); end
      4'd1: begin ma = DW'(xr); mb = lslf_pkg::PW'(xr); end
      4'd2: begin ma = DW'($signed({1'b0, n})); mb = sxx; end
      4'd3: begin ma = DW'(sx); mb = lslf_pkg::PW'(sx); end
      4'd4: begin ma = DW'($signed({1'b0, n})); mb = sxy; end
      4'd5: begin ma = DW'(sx); mb = lslf_pkg::PW'(sy); end
      4'd6: begin ma = DW'(sy); mb = sxx; end
      4'd7: begin ma = DW'(sx); mb = sxy; end
      default: ;
    endcase
  end
  lslf_mul u_mul (.clk, .rst, .start(cmd.mul_start), .a(ma), .b(mb),
                  .busy(mbusy), .prod);

  assign dnum = cmd.div_sel ? inum : (snum <<< 16);
  lslf_div u_div (.clk, .rst, .start(cmd.div_start), .num(dnum), .den(den),
                  .busy(dbusy), .q);

  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0; sy <= '0; sxy <= '0; sxx <= '0; n <= '0;
      done <= 1'b0; degen <= 1'b0;
    end else begin
      if (cmd.load) begin
        xr <= x_in;
        yr <= y_in;
        if (restart) begin
          sx <= lslf_pkg::SW'(x_in);
          sy <= lslf_pkg::SW'(y_in);
          n <= 6'd1;
        end else begin
          sx <= sx + lslf_pkg::SW'(x_in);
          sy <= sy + lslf_pkg::SW'(y_in);
          if (n < 6'd63) n <= n + 6'd1;
        end
        if (restart) begin sxy <= '0; sxx <= '0; end
      end
      // Writeback of product terms.
      if (cmd.mul_acc) begin
        case (cmd.mul_sel)
          4'd0: sxy <= sxy + prod[lslf_pkg::PW-1:0];
          4'd1: sxx <= sxx + prod[lslf_pkg::PW-1:0];
          4'd2: t <= prod;
          4'd3: den <= t - prod;
          4'd4: t <= prod;
          4'd5: snum <= t - prod;
          4'd6: t <= prod;
          4'd7: inum <= t - prod;
          default: ;
        endcase
      end
      if (cmd.out_load) begin
        if (cmd.div_sel) intercept <= q;
        else slope <= q;
      end
      if (cmd.load) begin
        done <= 1'b0; degen <= 1'b0; slope <= '0; intercept <= '0;
      end
      if (cmd.fit_end) begin
        done <= 1'b1;
        degen <= !(den > 0);
        if (!(den > 0)) begin slope <= '0; intercept <= '0; end
        sx <= '0; sy <= '0; sxy <= '0; sxx <= '0; n <= '0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.load) taken <= restart ? lslf_pkg::NW'(1)
                          : (n < 6'd63 ? lslf_pkg::NW'(n + 6'd1) : lslf_pkg::NW'(n));
  end
  assign stat.mul_busy = mbusy;
  assign stat.div_busy = dbusy;
  assign stat.target_hit = (n >= tgt);
  assign stat.den_pos = (den > 0);
endmodule
`default_nettype wire

// File: src/lslf_ctrl.sv
// Controller: sequences accumulate, fit products and divisions per point.
// Depends on lslf_pkg.
`default_nettype none
module lslf_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output lslf_pkg::cmd_t cmd,
  input  wire lslf_pkg::stat_t stat
);
  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_WAIT = 3'd2,
                         S_CHK = 3'd3, S_DIV = 3'd4, S_DWAIT = 3'd5, S_OUT = 3'd6;
  logic [2:0] state;
  logic [3:0] sel;
  logic dsel;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.mul_sel = sel;
    cmd.div_sel = dsel;
    cmd.load = in_valid && in_ready;
    unique case (state)
      S_MUL: cmd.mul_start = 1'b1;
      S_WAIT: cmd.mul_acc = !stat.mul_busy;
      S_DIV: cmd.div_start = 1'b1;
      S_DWAIT: cmd.out_load = !stat.div_busy;
      S_OUT: cmd.fit_end = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      sel <= '0;
      dsel <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd.load) begin sel <= '0; state <= S_MUL; end
        S_MUL: state <= S_WAIT;
        S_WAIT: if (!stat.mul_busy) begin
          if (sel == 4'd1) begin
            state <= S_CHK;
          end else if (sel == 4'd7) begin
            dsel <= 1'b0;
            state <= S_DIV;
          end else begin
            sel <= sel + 4'd1;
            state <= S_MUL;
          end
        end
        S_CHK: if (stat.target_hit) begin
          sel <= 4'd2; state <= S_MUL;
        end else begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        S_DIV: if (!stat.den_pos) state <= S_OUT;
               else state <= S_DWAIT;
        S_DWAIT: if (!stat.div_busy) begin
          if (dsel) state <= S_OUT;
          else begin dsel <= 1'b1; state <= S_DIV; end
        end
        S_OUT: begin out_valid <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/least_squares_line_fit_unit.sv
// Least-squares line fit unit: top level joining controller and datapath.
// Depends on lslf_pkg, lslf_ctrl, lslf_datapath.
// Usage:
//  s_axis: one word per calibration point, tdata = {y, x}, tuser = restart.
//  m_axis: one word per point: points taken, fit flags, slope and intercept.
//  cfg_we/cfg_data set the points per fit (0 reads as 1, above MAX_POINTS
//  clamps). Write only while idle.
//  A point that does not complete a run needs two serial products through the
//  shared 4-bit-per-step multiplier. A point that completes a run adds six more
//  products and, when the denominator is positive, two 88-step divisions.
//  One point at a time: s_axis_tready is low while a point is in work or
//  its result waits; a stalled receiver simply holds the result word.
//  Reset clears sums and count and sets points per fit to 1.
`default_nettype none
module least_squares_line_fit_unit #(
  parameter int MAX_POINTS = lslf_pkg::MaxPointsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [4:0] cfg_data,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // [16:0] drive_voltage, [33:17] received_voltage, zero fill
  input  wire logic [39:0] s_axis_tdata,
  // [0] restart
  input  wire logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // [4:0] points_taken, [36:5] slope, [68:37] intercept, zero fill
  output logic [71:0] m_axis_tdata,
  // [0] fit_done, [1] fit_degenerate
  output logic [1:0] m_axis_tuser
);
  lslf_pkg::cmd_t cmd;
  lslf_pkg::stat_t stat;
  logic [4:0] taken;
  logic done, degen;
  logic signed [31:0] slope, intercept;

  lslf_ctrl u_ctrl (.clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
                    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .cmd, .stat);
  lslf_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_data,
    .x_in(s_axis_tdata[16:0]), .y_in(s_axis_tdata[33:17]), .restart(s_axis_tuser),
    .cmd, .stat, .taken, .done, .degen, .slope, .intercept);

  assign m_axis_tdata = {3'b000, intercept, slope, taken};
  assign m_axis_tuser = {degen, done};
endmodule
`default_nettype wire

// File: src/lslf_checker.sv
// Port-level checker for the line fit unit, bound to the top level.
// Depends on least_squares_line_fit_unit ports only.
`default_nettype none
module lslf_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [71:0] m_axis_tdata,
  input wire logic [1:0] m_axis_tuser
);
  // degenerate only with done
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0]) else $error("degen without done");
  // no input taken while a result waits
  a_one: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  // no result on the edge right after an accept
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("result too early");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result changed");
endmodule
bind least_squares_line_fit_unit lslf_checker u_lslf_checker (.*);
`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for least_squares_line_fit_unit: streams calibration points, predicts
// each result word (running sums, least-squares slope and intercept) and checks it.
// Depends on lslf_pkg and least_squares_line_fit_unit.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPts = lslf_pkg::MaxPointsDefault;
  localparam longint CycleLimit = 4000000;
  localparam int DrainPause = 300;
  localparam logic [16:0] VMax = 17'sd61440;
  localparam logic [16:0] VMin = -17'sd61440;

  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic restart;
  } point_t;

  typedef struct packed {
    logic [4:0] taken;
    logic done;
    logic degen;
    logic [31:0] slope;
    logic [31:0] icpt;
  } fit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  // predictor state
  logic [4:0] pts_per_fit = 5'd1;
  longint sum_x, sum_y, sum_xy, sum_xx;
  int pts_in_run;

  point_t point_q[$];
  fit_t fit_q[$];
  point_t cur_point;
  int idle_max = 4;
  int gap_left = 0;
  int stall_left = 0;
  int errors = 0;
  int words_in = 0, words_out = 0, fits_seen = 0, degen_seen = 0;
  int words_queued = 0;
  longint cycles = 0;

  least_squares_line_fit_unit #(.MAX_POINTS(MaxPts)) u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  // num/den rounded half away from zero, saturated to 32 bits
  function automatic logic [31:0] div_round_sat(longint num, longint den);
    logic neg;
    longint unsigned mag, q;
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -q[31:0];
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic void clear_sums();
    sum_x = 0; sum_y = 0; sum_xy = 0; sum_xx = 0; pts_in_run = 0;
  endfunction

  // add one point to the run and work out the result word
  function automatic fit_t fit_point(point_t p);
    fit_t r;
    longint x, y, n, den, snum, inum;
    int target;
    x = $signed(p.x);
    y = $signed(p.y);
    target = (pts_per_fit == 0) ? 1 : (pts_per_fit > MaxPts ? MaxPts : pts_per_fit);
    r = '0;
    if (p.restart) clear_sums();
    sum_x += x; sum_y += y; sum_xy += x * y; sum_xx += x * x;
    if (pts_in_run < 63) pts_in_run++;
    r.taken = pts_in_run[4:0];
    if (pts_in_run >= target) begin
      n = pts_in_run;
      den = n * sum_xx - sum_x * sum_x;
      r.done = 1'b1;
      if (den <= 0) begin
        r.degen = 1'b1;
      end else begin
        snum = n * sum_xy - sum_x * sum_y;
        inum = sum_y * sum_xx - sum_x * sum_xy;
        r.slope = div_round_sat(snum * 65536, den);
        r.icpt = div_round_sat(inum, den);
      end
      clear_sums();
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH word %0d %s: got %h want %h", words_out, what, got, want);
  endtask

  // point driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        fit_q.push_back(fit_point(cur_point));
        words_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (point_q.size() > 0) begin
          cur_point = point_q.pop_front();
          s_axis_tdata <= {6'b0, cur_point.y, cur_point.x};
          s_axis_tuser <= cur_point.restart;
          s_axis_tvalid <= 1'b1;
          gap_left = $urandom_range(0, idle_max);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stalls
  always @(posedge clk) begin
    fit_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[4:0], m_axis_tuser[0], m_axis_tuser[1],
               m_axis_tdata[36:5], m_axis_tdata[68:37]};
        words_out++;
        if (fit_q.size() == 0) begin
          report("unexpected word", 32'(got.taken), 32'h0);
        end else begin
          want = fit_q.pop_front();
          if (got.taken != want.taken) report("points_taken", 32'(got.taken), 32'(want.taken));
          if (got.done != want.done) report("fit_done", 32'(got.done), 32'(want.done));
          if (got.degen != want.degen) report("fit_degenerate", 32'(got.degen), 32'(want.degen));
          if (got.slope != want.slope) report("slope", got.slope, want.slope);
          if (got.icpt != want.icpt) report("intercept", got.icpt, want.icpt);
          if (want.done) fits_seen++;
          if (want.degen) degen_seen++;
        end
        stall_left = $urandom_range(0, idle_max);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, fit_q.size());
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [16:0] rand_volt();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? VMax : VMin;
      1: return 17'($urandom);
      2: return 17'($signed($urandom_range(0, 64)) - 32);
      default: return 17'($signed($urandom_range(0, 122880)) - 61440);
    endcase
  endfunction

  task automatic add_point(logic [16:0] x, logic [16:0] y, logic restart);
    point_q.push_back('{x: x, y: y, restart: restart});
    words_queued++;
  endtask

  // wait until every queued point has come back as a result word
  task automatic drain();
    while (words_out < words_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_count(logic [4:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pts_per_fit = v;
  endtask

  initial begin
    int target, npts, gain, offs;
    logic [16:0] x;
    clear_sums();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset count of one: every point closes a degenerate fit
    add_point(VMax, VMin, 1'b0);
    add_point(-17'sd65536, 17'sd65535, 1'b1);
    drain();

    // two-point fits: extremes, zero, vertical line and a saturating slope
    set_count(5'd2);
    add_point(VMin, VMin, 1'b0); add_point(VMax, VMax, 1'b0);
    add_point(VMax, VMin, 1'b0); add_point(VMin, VMax, 1'b0);
    add_point(17'd0, 17'd0, 1'b0); add_point(17'd0, 17'd0, 1'b0);
    add_point(17'd7, 17'd5, 1'b0); add_point(17'd7, -17'sd9, 1'b0);
    add_point(17'd0, -17'sd65536, 1'b0); add_point(17'd1, 17'sd65535, 1'b0);
    add_point(17'd1, 17'sd65535, 1'b0); add_point(17'd0, -17'sd65536, 1'b0);
    // restart mid-run drops the stray point
    add_point(17'd100, 17'd3, 1'b0); add_point(17'd4096, 17'd8192, 1'b1);
    add_point(17'd8192, 17'd4096, 1'b0);
    drain();

    // count lowered mid-run: next point closes the run
    set_count(5'd5);
    add_point(17'd4096, 17'd4100, 1'b0); add_point(17'd8192, 17'd8190, 1'b0);
    add_point(17'd12288, 17'd12300, 1'b0);
    drain();
    set_count(5'd2);
    add_point(17'd16384, 17'd16000, 1'b0);
    drain();

    // zero and over-range counts
    set_count(5'd0);
    add_point(17'd3, 17'd4, 1'b0);
    drain();
    set_count(5'd31);
    for (int i = 0; i < 16; i++) add_point(VMin + 17'(i * 8192), rand_volt(), 1'b0);
    drain();

    // random phases: mostly points near a line, some noise and restarts
    while (words_in < 1000) begin
      idle_max = ($urandom_range(0, 4) == 0) ? 0 : 4;
      case ($urandom_range(0, 5))
        0: set_count(5'($urandom));
        1: set_count(5'd16);
        default: set_count(5'($urandom_range(2, 8)));
      endcase
      target = (pts_per_fit == 0) ? 1 : (pts_per_fit > MaxPts ? MaxPts : pts_per_fit);
      npts = target * $urandom_range(1, 3) + $urandom_range(0, 1);
      gain = $urandom_range(0, 4096) - 2048;
      offs = $urandom_range(0, 8192) - 4096;
      for (int i = 0; i < npts; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          add_point(rand_volt(), rand_volt(), $urandom_range(0, 19) == 0);
        end else begin
          x = 17'($signed($urandom_range(0, 30000)) - 15000);
          add_point(x, 17'(($signed(x) * gain) / 1024 + offs + $signed($urandom_range(0, 40)) - 20),
                    $urandom_range(0, 29) == 0);
        end
      end
      drain();
      repeat (DrainPause) @(posedge clk);
    end

    $display("%0d points sent, %0d result words, %0d fits of which %0d degenerate",
             words_in, words_out, fits_seen, degen_seen);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
src/lslf_pkg.sv
src/lslf_mul.sv
src/lslf_div.sv
src/lslf_datapath.sv
src/lslf_ctrl.sv
src/least_squares_line_fit_unit.sv
src/lslf_checker.sv
tb/sv/tb.sv
